// ----- rtl/core/wdr_pkg.sv -----
// wdr_pkg: shared constants, types and helper functions of the water drop synthesiser.
// Holds the cosine coefficient table built at elaboration time.
// No dependencies.
package wdr_pkg;

  // table and resonator sizes
  localparam int COS_TABLE_DEPTH = 1024;
  localparam int NUM_RESONATORS  = 3;
  localparam int COS_AW          = $clog2(COS_TABLE_DEPTH);

  // divider for the table index: dividend is (f*2D + fs<<14) >> 15
  localparam int NUM_W = 32 + COS_AW + 2;
  localparam int QUO_W = NUM_W - 15;
  localparam int FS_W  = 18;

  // square root unit: 46-bit radicand, 23-bit root
  localparam int SQ_W   = 46;
  localparam int ROOT_W = 23;
  localparam int REM_W  = 27;
  localparam int CNT_W  = $clog2(QUO_W);

  // port widths
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 18;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESONANCE_HZ = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JITTER_DEPTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE  = 3'd4;

  // Q2.22 constants
  localparam logic signed [25:0] Q_ONE      = 26'sd4194304;
  localparam logic signed [25:0] POLE_Q     = 26'sd4188013;
  localparam logic signed [25:0] POLE_SQ_Q  = 26'sd4181731;
  localparam logic signed [25:0] SWEEP_Q    = 26'sd4194723;
  localparam logic signed [25:0] DECAY_Q    = 26'sd3984589;
  localparam logic signed [23:0] GAIN_FLOOR = 24'sd4194;
  localparam logic [23:0]        PAN_RESET  = 24'd3187671;
  localparam logic [63:0]        TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0]        TWO_POLE_Q = 64'd8376025;

  // table addresses of the reset coefficients (600, 1200, 1800 Hz at 44100 Hz)
  localparam int RST_IDX0 = ((600 * 2 * COS_TABLE_DEPTH + 44100) / 88200) % COS_TABLE_DEPTH;
  localparam int RST_IDX1 = ((1200 * 2 * COS_TABLE_DEPTH + 44100) / 88200) % COS_TABLE_DEPTH;
  localparam int RST_IDX2 = ((1800 * 2 * COS_TABLE_DEPTH + 44100) / 88200) % COS_TABLE_DEPTH;

  typedef logic signed [23:0] coeff_t;
  typedef coeff_t coeff_rom_t [COS_TABLE_DEPTH];

  // handshake between sequencer and iterative unit
  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } iu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iu_rsp_t;

  // x / 32767 by reciprocal series and one correction step
  function automatic logic [24:0] div32767(input logic [39:0] x);
    logic [39:0] est;
    logic [39:0] q0;
    logic [39:0] r;
    est = x + (x >> 15) + (x >> 30);
    q0  = est >> 15;
    r   = x - ((q0 << 15) - q0);
    return (r >= 40'd32767) ? 25'(q0 + 40'd1) : 25'(q0);
  endfunction

  // random word to Q2.22 noise in about [-0.5, 0.5]
  function automatic logic signed [23:0] word_noise(input logic [14:0] r);
    logic signed [15:0] d;
    logic [14:0]        mag;
    logic [24:0]        q;
    d   = $signed({1'b0, r}) - 16'sd16384;
    mag = d[15] ? 15'(-d) : 15'(d);
    q   = div32767((40'(mag) << 22) + 40'd16383);
    return d[15] ? -$signed(24'(q)) : $signed(24'(q));
  endfunction

  // saturate to signed 24 bit
  function automatic logic signed [23:0] sat24(input logic signed [59:0] v);
    if (v > 60'sd8388607) begin
      return 24'sd8388607;
    end else if (v < -60'sd8388608) begin
      return -24'sd8388608;
    end
    return v[23:0];
  endfunction

  // -1.997*cos table by polynomial series, one entry per phase step
  function automatic coeff_rom_t build_coeff_rom();
    coeff_rom_t  rom;
    logic [63:0] x;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] t;
    logic [63:0] v;
    logic [63:0] tmp;
    logic        neg;
    for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
      x   = (64'(k) << 30) / COS_TABLE_DEPTH;
      neg = 1'b0;
      if (x > (64'd1 << 29)) x = (64'd1 << 30) - x;
      if (x > (64'd1 << 28)) begin
        x   = (64'd1 << 29) - x;
        neg = 1'b1;
      end
      a  = (x * TWO_PI_Q30) >> 30;
      a2 = (a * a) >> 30;
      t  = 64'd1 << 30;
      tmp = ((a2 * t) >> 30) / 182;
      t   = (tmp > (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - tmp;
      tmp = ((a2 * t) >> 30) / 132;
      t   = (tmp > (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - tmp;
      tmp = ((a2 * t) >> 30) / 90;
      t   = (tmp > (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - tmp;
      tmp = ((a2 * t) >> 30) / 56;
      t   = (tmp > (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - tmp;
      tmp = ((a2 * t) >> 30) / 30;
      t   = (tmp > (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - tmp;
      tmp = ((a2 * t) >> 30) / 12;
      t   = (tmp > (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - tmp;
      tmp = ((a2 * t) >> 30) / 2;
      t   = (tmp > (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - tmp;
      v = (t * TWO_POLE_Q + (64'd1 << 29)) >> 30;
      rom[k] = neg ? $signed(24'(v)) : -$signed(24'(v));
    end
    return rom;
  endfunction

  localparam coeff_rom_t COEFF_ROM = build_coeff_rom();

endpackage

// ----- rtl/core/wdr_iter_unit.sv -----
// wdr_iter_unit: shared compare/subtract unit, one quotient or root bit per cycle.
// Restoring division for the table index, digit-by-digit square root for the pan.
// Depends on wdr_pkg.
module wdr_iter_unit import wdr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  iu_req_t          req,
  input  logic [QUO_W-1:0] div_num,
  input  logic [FS_W-1:0]  div_den,
  input  logic [SQ_W-1:0]  sq_val,
  output iu_rsp_t          rsp,
  output logic [QUO_W-1:0] result
);

  logic             busy_r;
  logic             done_r;
  logic             mode_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SQ_W-1:0]  src_r;
  logic [FS_W-1:0]  den_r;
  logic [REM_W-1:0] rem_r;
  logic [QUO_W-1:0] res_r;

  logic [REM_W-1:0] op_x;
  logic [REM_W-1:0] op_y;
  logic             ge;
  logic             last;

  // shared trial subtraction
  always_comb begin
    if (mode_r) begin
      op_x = {rem_r[REM_W-3:0], src_r[SQ_W-1:SQ_W-2]};
      op_y = REM_W'({res_r[ROOT_W-1:0], 2'b01});
      last = (cnt_r == CNT_W'(ROOT_W - 1));
    end else begin
      op_x = {rem_r[REM_W-2:0], src_r[QUO_W-1]};
      op_y = REM_W'(den_r);
      last = (cnt_r == CNT_W'(QUO_W - 1));
    end
    ge = (op_x >= op_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      mode_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        mode_r <= req.sqrt_mode;
        cnt_r  <= '0;
        src_r  <= req.sqrt_mode ? sq_val : SQ_W'(div_num);
        den_r  <= div_den;
        rem_r  <= '0;
        res_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? (op_x - op_y) : op_x;
        res_r <= {res_r[QUO_W-2:0], ge};
        src_r <= mode_r ? (src_r << 2) : (src_r << 1);
        cnt_r <= cnt_r + CNT_W'(1);
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp    = '{busy: busy_r, done: done_r};
  assign result = res_r;

endmodule

// ----- rtl/core/water_drop_resonator_synth.sv -----
// An item without a drop or sweep passes only the drop-free states; a drop adds two
// 23-step square roots (left and right pan), each sweeping resonator a 29-step index divide.
// Items are taken one at a time: a new item is accepted only after the last result is
// loaded; the shared multiplier and the bit-serial divide/root unit set the pace.
// Reset (synchronous, rst_n low): registers to their defaults, resonators silent,
// pan at 0.76, coefficients tuned to 600/1200/1800 Hz.
// Top level of the water drop synthesiser; depends on wdr_pkg and wdr_iter_unit.
module water_drop_resonator_synth import wdr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // rand_event, rand_pan, rand_select, rand_jitter, rand_gain, rand_excite (15 bit each)
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // left_sample, right_sample (24 bit signed each)
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // sequencer states
  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_DROP0 = 5'd1;
  localparam logic [4:0] ST_DROP1 = 5'd2;
  localparam logic [4:0] ST_DROP2 = 5'd3;
  localparam logic [4:0] ST_SQL   = 5'd4;
  localparam logic [4:0] ST_SQLW  = 5'd5;
  localparam logic [4:0] ST_SQR   = 5'd6;
  localparam logic [4:0] ST_SQRW  = 5'd7;
  localparam logic [4:0] ST_GAIN0 = 5'd8;
  localparam logic [4:0] ST_GAIN1 = 5'd9;
  localparam logic [4:0] ST_SWEEP = 5'd10;
  localparam logic [4:0] ST_DIVW  = 5'd11;
  localparam logic [4:0] ST_COEF  = 5'd12;
  localparam logic [4:0] ST_EXC0  = 5'd13;
  localparam logic [4:0] ST_EXC1  = 5'd14;
  localparam logic [4:0] ST_EXC2  = 5'd15;
  localparam logic [4:0] ST_RES0  = 5'd16;
  localparam logic [4:0] ST_RES1  = 5'd17;
  localparam logic [4:0] ST_RES2  = 5'd18;
  localparam logic [4:0] ST_RES3  = 5'd19;
  localparam logic [4:0] ST_FIN0  = 5'd20;
  localparam logic [4:0] ST_FIN1  = 5'd21;
  localparam logic [4:0] ST_FIN2  = 5'd22;
  localparam logic [4:0] ST_FIN3  = 5'd23;

  localparam logic [1:0] LAST_RES = 2'(NUM_RESONATORS - 1);

  logic [4:0] state_r;
  logic [4:0] state_nxt;
  logic [1:0] idx_r;

  // configuration
  logic [9:0]      drop_count_r;
  logic [14:0]     resonance_hz_r;
  logic [15:0]     spread_r;
  logic [15:0]     jitter_depth_r;
  logic [FS_W-1:0] sample_rate_r;

  // latched item fields
  logic [14:0] rpan_r;
  logic [14:0] rsel_r;
  logic [14:0] rjit_r;
  logic [14:0] rgain_r;
  logic [14:0] rexc_r;

  // synth state
  logic signed [23:0] excite_r;
  logic [23:0]        pan_left_r;
  logic [23:0]        pan_right_r;
  logic [31:0]        freq_r  [NUM_RESONATORS];
  logic signed [23:0] gain_r  [NUM_RESONATORS];
  logic signed [23:0] coeff_r [NUM_RESONATORS];
  logic signed [23:0] hist0_r [NUM_RESONATORS];
  logic signed [23:0] hist1_r [NUM_RESONATORS];
  logic signed [23:0] fd0_r;
  logic signed [23:0] fd1_r;
  logic signed [23:0] fd2_r;

  // working registers
  logic signed [26:0] acc_r;
  logic signed [25:0] sum_r;
  logic signed [23:0] drive_r;
  logic signed [24:0] diff_r;
  logic signed [23:0] left_r;
  logic signed [59:0] prod_r;
  logic signed [23:0] rom_q_r;
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  // shared multiplier operands
  logic signed [33:0] mul_a;
  logic signed [25:0] mul_b;

  logic               in_acc;
  logic               drop;
  logic [29:0]        ev_prod;
  logic signed [59:0] prod_sh;
  logic signed [23:0] noise_jit;
  logic signed [23:0] noise_gain;
  logic signed [23:0] noise_exc;
  logic [16:0]        sel_prod;
  logic [1:0]         sel;
  logic signed [26:0] s6;
  logic signed [26:0] jsh;
  logic signed [26:0] factor;
  logic [59:0]        prod_abs;
  logic [59:0]        mag_full;
  logic [31:0]        mag;
  logic [21:0]        pan_p;
  logic [31:0]        f_sat;
  logic [FS_W-1:0]    fs_eff;
  logic [NUM_W-1:0]   num_full;
  logic signed [26:0] y_full;
  logic signed [23:0] y;
  logic signed [23:0] four_sum;
  logic               out_free;

  iu_req_t            iu_req;
  iu_rsp_t            iu_rsp;
  logic [QUO_W-1:0]   iu_result;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // drop decision: (rand_event*32767)>>15 < drop_count
  assign ev_prod = (30'(in_tdata[14:0]) << 15) - 30'(in_tdata[14:0]);
  assign drop    = (ev_prod[29:15] < 15'(drop_count_r));

  // noise words and drop parameters
  assign noise_jit  = word_noise(rjit_r);
  assign noise_gain = word_noise(rgain_r);
  assign noise_exc  = word_noise(rexc_r);
  assign prod_sh    = prod_r >>> 22;
  assign sel_prod   = 17'(rsel_r) * 17'd3;
  assign sel        = sel_prod[16:15];
  assign s6         = $signed({5'b0, spread_r, 6'b0});
  assign jsh        = 27'(signed'(prod_r[39:16]));
  assign pan_p      = 22'(div32767((40'(rpan_r) << 21) + 40'd16383));

  always_comb begin
    unique case (sel)
      2'd0:    factor = 27'(Q_ONE) - s6 + jsh;
      2'd1:    factor = 27'(Q_ONE) + jsh;
      default: factor = 27'(Q_ONE) + (s6 <<< 1) + (jsh <<< 1);
    endcase
  end

  // frequency magnitude from resonance * factor, saturated
  assign prod_abs = prod_r[59] ? 60'(-prod_r) : 60'(prod_r);
  assign mag_full = prod_abs >> 8;
  assign mag      = (|mag_full[59:32]) ? 32'hFFFF_FFFF : mag_full[31:0];

  // swept frequency and table index dividend
  assign f_sat    = (|prod_r[59:54]) ? 32'hFFFF_FFFF : prod_r[53:22];
  assign fs_eff   = (sample_rate_r == '0) ? FS_W'(1) : sample_rate_r;
  assign num_full = (NUM_W'(f_sat) << (COS_AW + 1)) + (NUM_W'(fs_eff) << 14);

  // resonator output and delay line input
  assign y_full   = acc_r - prod_sh[26:0];
  assign y        = sat24(60'(y_full));
  assign four_sum = sat24(60'(sum_r) <<< 2);

  // iterative unit requests
  always_comb begin
    iu_req.start     = (state_r == ST_SQL) || (state_r == ST_SQR) || (state_r == ST_SWEEP);
    iu_req.sqrt_mode = (state_r != ST_SWEEP);
  end

  wdr_iter_unit u_iter (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (iu_req),
    .div_num (num_full[NUM_W-1:15]),
    .div_den (fs_eff),
    .sq_val  ((state_r == ST_SQL) ? (SQ_W'(pan_p) << 22)
                                  : (SQ_W'(23'(Q_ONE) - 23'(pan_p)) << 22)),
    .rsp     (iu_rsp),
    .result  (iu_result)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_DROP0: begin
        mul_a = $signed({18'b0, jitter_depth_r});
        mul_b = 26'(noise_jit);
      end
      ST_DROP1: begin
        mul_a = $signed({19'b0, resonance_hz_r});
        mul_b = factor[25:0];
      end
      ST_GAIN0: begin
        mul_a = 34'(gain_r[idx_r]);
        mul_b = POLE_Q;
      end
      ST_GAIN1: begin
        mul_a = $signed({2'b0, freq_r[idx_r]});
        mul_b = SWEEP_Q;
      end
      ST_EXC0: begin
        mul_a = 34'(excite_r);
        mul_b = DECAY_Q;
      end
      ST_EXC1: begin
        mul_a = 34'(signed'(prod_sh[23:0]));
        mul_b = 26'(noise_exc);
      end
      ST_RES0: begin
        mul_a = 34'(drive_r);
        mul_b = 26'(gain_r[idx_r]);
      end
      ST_RES1: begin
        mul_a = 34'(hist0_r[idx_r]);
        mul_b = 26'(coeff_r[idx_r]);
      end
      ST_RES2: begin
        mul_a = 34'(hist1_r[idx_r]);
        mul_b = POLE_SQ_Q;
      end
      ST_FIN1: begin
        mul_a = 34'(diff_r);
        mul_b = $signed({2'b0, pan_left_r});
      end
      ST_FIN2, ST_FIN3: begin
        mul_a = 34'(diff_r);
        mul_b = $signed({2'b0, pan_right_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // product and table read registers
  always_ff @(posedge clk) begin
    prod_r  <= mul_a * mul_b;
    rom_q_r <= COEFF_ROM[iu_result[COS_AW-1:0]];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = drop ? ST_DROP0 : ST_GAIN0;
      ST_DROP0: state_nxt = ST_DROP1;
      ST_DROP1: state_nxt = ST_DROP2;
      ST_DROP2: state_nxt = ST_SQL;
      ST_SQL:   state_nxt = ST_SQLW;
      ST_SQLW:  if (iu_rsp.done) state_nxt = ST_SQR;
      ST_SQR:   state_nxt = ST_SQRW;
      ST_SQRW:  if (iu_rsp.done) state_nxt = ST_GAIN0;
      ST_GAIN0: state_nxt = ST_GAIN1;
      ST_GAIN1: begin
        if (signed'(prod_sh[23:0]) > GAIN_FLOOR) state_nxt = ST_SWEEP;
        else state_nxt = (idx_r == LAST_RES) ? ST_EXC0 : ST_GAIN0;
      end
      ST_SWEEP: state_nxt = ST_DIVW;
      ST_DIVW:  if (iu_rsp.done) state_nxt = ST_COEF;
      ST_COEF:  state_nxt = (idx_r == LAST_RES) ? ST_EXC0 : ST_GAIN0;
      ST_EXC0:  state_nxt = ST_EXC1;
      ST_EXC1:  state_nxt = ST_EXC2;
      ST_EXC2:  state_nxt = ST_RES0;
      ST_RES0:  state_nxt = ST_RES1;
      ST_RES1:  state_nxt = ST_RES2;
      ST_RES2:  state_nxt = ST_RES3;
      ST_RES3:  state_nxt = (idx_r == LAST_RES) ? ST_FIN0 : ST_RES0;
      ST_FIN0:  state_nxt = ST_FIN1;
      ST_FIN1:  state_nxt = ST_FIN2;
      ST_FIN2:  state_nxt = ST_FIN3;
      ST_FIN3:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      idx_r          <= '0;
      drop_count_r   <= 10'd4;
      resonance_hz_r <= 15'd500;
      spread_r       <= 16'd16384;
      jitter_depth_r <= 16'd16384;
      sample_rate_r  <= FS_W'(44100);
      excite_r       <= '0;
      pan_left_r     <= PAN_RESET;
      pan_right_r    <= PAN_RESET;
      for (int i = 0; i < NUM_RESONATORS; i++) begin
        freq_r[i]  <= '0;
        gain_r[i]  <= '0;
        hist0_r[i] <= '0;
        hist1_r[i] <= '0;
      end
      coeff_r[0]   <= COEFF_ROM[RST_IDX0];
      coeff_r[1]   <= COEFF_ROM[RST_IDX1];
      coeff_r[2]   <= COEFF_ROM[RST_IDX2];
      fd0_r        <= '0;
      fd1_r        <= '0;
      fd2_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DROP_COUNT:   drop_count_r   <= cfg_wdata[9:0];
          CFG_RESONANCE_HZ: resonance_hz_r <= cfg_wdata[14:0];
          CFG_SPREAD:       spread_r       <= cfg_wdata[15:0];
          CFG_JITTER_DEPTH: jitter_depth_r <= cfg_wdata[15:0];
          CFG_SAMPLE_RATE:  sample_rate_r  <= cfg_wdata;
          default: ;
        endcase
      end

      // result slot: loaded at the end of an item, cleared once taken
      if ((state_r == ST_FIN3) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            rpan_r  <= in_tdata[29:15];
            rsel_r  <= in_tdata[44:30];
            rjit_r  <= in_tdata[59:45];
            rgain_r <= in_tdata[74:60];
            rexc_r  <= in_tdata[89:75];
            idx_r   <= '0;
          end
        end
        ST_DROP2: begin
          excite_r    <= 24'(Q_ONE);
          freq_r[sel] <= mag;
          gain_r[sel] <= noise_gain[23] ? -noise_gain : noise_gain;
        end
        ST_SQLW: if (iu_rsp.done) pan_left_r <= iu_result[23:0];
        ST_SQRW: if (iu_rsp.done) pan_right_r <= iu_result[23:0];
        ST_GAIN1: begin
          gain_r[idx_r] <= prod_sh[23:0];
          if (!(signed'(prod_sh[23:0]) > GAIN_FLOOR)) idx_r <= idx_r + 2'd1;
        end
        ST_SWEEP: freq_r[idx_r] <= f_sat;
        ST_COEF: begin
          coeff_r[idx_r] <= rom_q_r;
          idx_r          <= idx_r + 2'd1;
        end
        ST_EXC1: excite_r <= prod_sh[23:0];
        ST_EXC2: begin
          drive_r <= prod_sh[23:0];
          idx_r   <= '0;
          sum_r   <= '0;
        end
        ST_RES1: acc_r <= prod_sh[26:0];
        ST_RES2: acc_r <= acc_r - prod_sh[26:0];
        ST_RES3: begin
          hist1_r[idx_r] <= hist0_r[idx_r];
          hist0_r[idx_r] <= y;
          sum_r          <= sum_r + 26'(y);
          idx_r          <= idx_r + 2'd1;
        end
        ST_FIN0: begin
          fd2_r  <= fd1_r;
          fd1_r  <= fd0_r;
          fd0_r  <= four_sum;
          diff_r <= 25'(fd1_r) - 25'(four_sum);
        end
        ST_FIN2: left_r <= sat24(prod_sh);
        ST_FIN3: begin
          if (out_free) begin
            out_tdata_r <= {sat24(prod_sh), left_r};
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ----- rtl/core/wdr_checker.sv -----
// wdr_checker: port-level assertions for the water drop synthesiser.
// Bound to water_drop_resonator_synth; depends on wdr_pkg.
module wdr_checker import wdr_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item dropped while stalled");

  // a stalled result item keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result data changed while stalled");

  // one item at a time: busy straight after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again while an item is in work");

  // reset clears the result slot
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind water_drop_resonator_synth wdr_checker u_wdr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
